// ----- rtl/core/lpht_pkg.sv -----
// Shared types and codes for the linear-probing hash table.
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int KEY_W      = 32;
    localparam int SLOT_FLD_W = 4;
    localparam int STATUS_W   = 2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_FLD_W-1:0] slot;
    } t_out_beat;

    // one table entry: occupancy plus stored key
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
    } t_slot;

endpackage

// ----- rtl/core/lpht_slot_ram.sv -----
// Single-port slot memory with registered read data.
`timescale 1ns / 1ps

module lpht_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_addr,
    input  lpht_pkg::t_slot      i_wdata,
    output lpht_pkg::t_slot      o_rdata
);
    import lpht_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lpht_home_div.sv -----
// Key mod SLOTS by reciprocal multiplication; a power-of-two table size takes a mask instead.
`timescale 1ns / 1ps

module lpht_home_div #(
    parameter int SLOTS = 16,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpht_pkg::KEY_W-1:0]  i_key,
    output logic                        o_done,
    output logic [IW-1:0]               o_home
);
    import lpht_pkg::*;

    localparam bit              POW2  = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int              HW    = KEY_W / 2;       // key half fed to the multiplier
    localparam int              MW    = KEY_W + 1;       // reciprocal width
    localparam int              PW    = HW + MW;         // partial product width
    localparam int              AW    = KEY_W + MW;      // full product width
    localparam int              SH    = KEY_W + IW;      // quotient shift
    // ceil(2^SH / SLOTS): exact quotient for every 32-bit key when SLOTS is not 2^n
    localparam logic [63:0]     MAG64 = ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [MW-1:0]   MAG   = MAG64[MW-1:0];

    localparam logic [1:0] STEP_LO  = 2'd0;
    localparam logic [1:0] STEP_HI  = 2'd1;
    localparam logic [1:0] STEP_FIX = 2'd2;

    logic             r_busy;
    logic             r_done;
    logic [1:0]       r_step;
    logic [IW-1:0]    r_rem;
    logic [KEY_W-1:0] r_key;
    logic [AW-1:0]    r_acc;

    logic [HW-1:0]    half;
    logic [PW-1:0]    part;
    logic [KEY_W-1:0] quo;
    logic [KEY_W-1:0] back;
    logic [KEY_W-1:0] diff;

    // one shared 16 x 33 multiplier: low half, then high half of the key
    always_comb begin
        half = (r_step == STEP_LO) ? r_key[HW-1:0] : r_key[KEY_W-1:HW];
        part = PW'(half) * PW'(MAG);
        quo  = KEY_W'(r_acc >> SH);
        back = quo * KEY_W'(SLOTS);
        diff = r_key - back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LO;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_key  <= i_key;
                r_step <= STEP_LO;
                r_acc  <= '0;
                if (POW2) begin
                    r_rem  <= i_key[IW-1:0];
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                case (r_step)
                    STEP_LO: begin
                        r_acc  <= AW'(part);
                        r_step <= STEP_HI;
                    end
                    STEP_HI: begin
                        r_acc  <= r_acc + (AW'(part) << HW);
                        r_step <= STEP_FIX;
                    end
                    STEP_FIX: begin
                        r_rem  <= diff[IW-1:0];
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    default: begin
                        r_step <= STEP_LO;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

// ----- rtl/core/linear_probing_hash_table.sv -----
// Open-addressing hash table with linear probing: top level and probe sequencer.
//
// Each input beat is an insert or a search of a 32-bit key; each produces exactly one
// result beat. The home slot is key mod SLOTS. An insert stores the key in the first
// empty slot from home (wrapping), duplicates included, and reports status 1 with slot 0
// when every slot is taken. A search reports the first occupied slot in probe order that
// holds the key, or status 3 with slot 0. Slot numbers wider than 4 bits are truncated.
// After reset the block sweeps the slot memory to mark every slot empty, with in_ready
// low. An item is then accepted, its home slot computed (a mask when SLOTS is a power
// of two, otherwise a reciprocal multiply and remainder fix-up), its slots probed
// through the single-port slot memory (one read per cycle, registered read data), the
// write of an insert made, and the result handed to the output register.
// One item is in flight at a time; the finished result waits in the output register, so
// a new beat is taken while an earlier result is still unclaimed.
`timescale 1ns / 1ps

module linear_probing_hash_table #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lpht_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lpht_pkg::t_out_beat   o_out_data
);
    import lpht_pkg::*;

    localparam int            IW   = $clog2(SLOTS);
    localparam int            CW   = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
    localparam logic [CW-1:0] NPRB = CW'(SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_WRITE,
        S_RESULT
    } t_state;

    t_state               r_state, n_state;
    logic                 r_op, n_op;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [IW-1:0]        r_addr, n_addr;       // clear sweep / probe read pointer
    logic [CW-1:0]        r_issued, n_issued;   // reads issued this item
    logic                 r_chk, n_chk;         // read data due for compare this cycle
    logic [IW-1:0]        r_chk_addr, n_chk_addr;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [IW-1:0]        r_slot, n_slot;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out_data, n_out_data;

    logic                 accept;
    logic [IW-1:0]        addr_inc;
    logic                 div_done;
    logic [IW-1:0]        div_home;
    logic                 ram_we;
    logic [IW-1:0]        ram_addr;
    t_slot                ram_wdata;
    t_slot                ram_rdata;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign addr_inc = (r_addr == LAST) ? '0 : IW'(r_addr + 1'b1);

    lpht_home_div #(
        .SLOTS (SLOTS)
    ) u_home_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_in_data.key),
        .o_done  (div_done),
        .o_home  (div_home)
    );

    lpht_slot_ram #(
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_addr      = r_addr;
        n_issued    = r_issued;
        n_chk       = r_chk;
        n_chk_addr  = r_chk_addr;
        n_status    = r_status;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        ram_we         = 1'b0;
        ram_addr       = r_addr;
        ram_wdata.used = 1'b0;
        ram_wdata.key  = r_key;

        // result beat taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = addr_inc;
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_in_data.operation;
                    n_key   = i_in_data.key;
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (div_done) begin
                    n_addr   = div_home;
                    n_issued = '0;
                    n_chk    = 1'b0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                // issue the next read while checking the previous one
                n_chk = 1'b0;
                if (r_issued != NPRB) begin
                    n_addr     = addr_inc;
                    n_issued   = CW'(r_issued + 1'b1);
                    n_chk      = 1'b1;
                    n_chk_addr = r_addr;
                end
                if (r_chk) begin
                    if (r_op == OP_INSERT && !ram_rdata.used) begin
                        n_slot   = r_chk_addr;
                        n_status = ST_INSERTED;
                        n_state  = S_WRITE;
                    end else if (r_op == OP_SEARCH && ram_rdata.used
                                 && ram_rdata.key == r_key) begin
                        n_slot   = r_chk_addr;
                        n_status = ST_FOUND;
                        n_state  = S_RESULT;
                    end else if (r_issued == NPRB) begin
                        // last slot checked, nothing fit
                        n_slot   = '0;
                        n_status = (r_op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        n_state  = S_RESULT;
                    end
                end
            end
            S_WRITE: begin
                ram_we         = 1'b1;
                ram_addr       = r_slot;
                ram_wdata.used = 1'b1;
                n_state        = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out_data.status = r_status;
                    n_out_data.slot   = SLOT_FLD_W'(r_slot);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issued    <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issued    <= n_issued;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_key      <= n_key;
        r_chk_addr <= n_chk_addr;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/lpht_checker.sv -----
// Port-level checks for the hash table, bound to the top level.
`timescale 1ns / 1ps

module lpht_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input lpht_pkg::t_in_beat   i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input lpht_pkg::t_out_beat  o_out_data
);
    import lpht_pkg::*;

    // reset leaves no result pending
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one item at a time: ready drops after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after input beat");

    // misses and drops always report slot zero
    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL || o_out_data.status == ST_NOT_FOUND)
        |-> o_out_data.slot == '0)
        else $error("nonzero slot on miss or full");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a waiting input beat stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while waiting");

endmodule

bind linear_probing_hash_table lpht_checker u_lpht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
